// ===== sv/assert_macros.svh =====
// Assertion macros shared by the waveform generator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PWG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define PWG_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/pwg_pkg.sv =====
// Shared widths, register indexes, mode codes and divider status type
// for the periodic waveform generator. No dependencies.
package pwg_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int PERIOD_WIDTH = 16;
   localparam int COUNT_WIDTH  = 32;
   localparam int MODE_WIDTH   = 2;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH =
      (COUNT_WIDTH >= SAMPLE_WIDTH && COUNT_WIDTH >= PERIOD_WIDTH) ? COUNT_WIDTH :
      (SAMPLE_WIDTH >= PERIOD_WIDTH) ? SAMPLE_WIDTH : PERIOD_WIDTH;

   // register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_WAVE_MODE  = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_AMPLITUDE  = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_PERIOD_LEN = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_HIGH_LEN   = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_TOTAL_LEN  = 3'd4;

   // waveform modes
   localparam logic [MODE_WIDTH-1:0] MODE_RECT = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_SYM  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_TRI  = 2'd2;

   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

   // divider: product magnitude over a period-sized divisor, two bits a cycle
   localparam int PROD_WIDTH    = SAMPLE_WIDTH + PERIOD_WIDTH;
   localparam int DIV_CYCLES    = (SAMPLE_WIDTH + 1) / 2;
   localparam int QUO_WIDTH     = 2 * DIV_CYCLES;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_CYCLES + 1);

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== sv/periodic_waveform_generator.sv =====
// Periodic waveform generator: one sample word out for each request word in.
// Rectangular modes: the sample is parked in HOLD, then moved to the output register.
// Triangle: MUL starts the serial divider (two quotient bits a cycle), DIV waits
// for it, HOLD parks the word; no new request is taken until the word leaves HOLD.
// Synchronous active-high reset: registers to defaults, counters to zero.
`include "assert_macros.svh"

module periodic_waveform_generator (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_restart,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [pwg_pkg::SAMPLE_WIDTH-1:0] rsp_sample,
   output logic [pwg_pkg::PERIOD_WIDTH-1:0]        rsp_phase_pos,
   output logic                                    rsp_last_sample,
   // register write port
   input  logic                                    csr_we,
   input  logic [pwg_pkg::CSR_ADDR_WIDTH-1:0]      csr_addr,
   input  logic [pwg_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata
);

   localparam int SW = pwg_pkg::SAMPLE_WIDTH;
   localparam int PW = pwg_pkg::PERIOD_WIDTH;
   localparam int CW = pwg_pkg::COUNT_WIDTH;

   // IDLE takes a word; MUL feeds the product to the divider; DIV waits;
   // HOLD parks the finished word until the output register is free.
   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_HOLD} state_type;

   state_type state_ff, state_in;

   // configuration
   logic [pwg_pkg::MODE_WIDTH-1:0] mode_ff, mode_in;
   logic [SW-1:0]                  amp_ff, amp_in;
   logic [PW-1:0]                  period_ff, period_in;
   logic [PW-1:0]                  high_ff, high_in;
   logic [CW-1:0]                  total_ff, total_in;

   // run state
   logic [PW-1:0] phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;

   // triangle operands, held across the divide
   logic [PW-1:0] factor_ff, factor_in;
   logic [PW-1:0] dvs_ff, dvs_in;
   logic          rising_ff, rising_in;
   logic          neg_ff, neg_in;

   // finished word waiting for the output register
   logic [SW-1:0] res_sample_ff, res_sample_in;
   logic [PW-1:0] res_phase_ff, res_phase_in;
   logic          res_last_ff, res_last_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_sample_ff, rsp_sample_in;
   logic [PW-1:0] rsp_phase_ff, rsp_phase_in;
   logic          rsp_last_ff, rsp_last_in;

   // effective lengths
   logic [PW-1:0] per_eff, high_eff;
   logic [CW-1:0] tot_eff;

   // accept-cycle working values
   logic          accept;
   logic [PW-1:0] j_raw, j_cur;
   logic [PW:0]   j_inc;
   logic [CW-1:0] cnt_raw, cnt_cur;
   logic          last_cur;
   logic          in_high;
   logic [SW-1:0] amp_neg, sym_low, quick_sample;

   // multiplier and divider
   logic [SW-1:0]                  amp_abs;
   logic [pwg_pkg::PROD_WIDTH-1:0] prod_mag;
   logic                           div_start;
   pwg_pkg::div_stat_type          div_stat;
   logic [SW-1:0]                  div_quo;
   logic [SW:0]                    quo_ext, quo_signed, amp_ext, tri_full;
   logic                           out_free;

   pwg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_mag),
      .divisor  (dvs_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // zero lengths behave as one; high part never longer than the period
   always_comb begin
      per_eff  = (period_ff == '0) ? {{(PW-1){1'b0}}, 1'b1} : period_ff;
      tot_eff  = (total_ff == '0) ? {{(CW-1){1'b0}}, 1'b1} : total_ff;
      high_eff = (high_ff > per_eff) ? per_eff : high_ff;
   end

   // restart clears, a counter left past its length by a register change folds to zero
   always_comb begin
      j_raw    = req_restart ? '0 : phase_ff;
      j_cur    = (j_raw >= per_eff) ? '0 : j_raw;
      cnt_raw  = req_restart ? '0 : count_ff;
      cnt_cur  = (cnt_raw >= tot_eff) ? '0 : cnt_raw;
      last_cur = (cnt_cur == tot_eff - {{(CW-1){1'b0}}, 1'b1});
      j_inc    = {1'b0, j_cur} + {{PW{1'b0}}, 1'b1};
      in_high  = (j_cur < high_eff);
   end

   // rectangular samples; -A of the most negative value saturates
   always_comb begin
      amp_neg = ~amp_ff + {{(SW-1){1'b0}}, 1'b1};
      sym_low = (amp_ff == pwg_pkg::SAMPLE_MIN) ? pwg_pkg::SAMPLE_MAX : amp_neg;
      unique case (mode_ff)
         pwg_pkg::MODE_RECT: quick_sample = in_high ? amp_ff : '0;
         pwg_pkg::MODE_SYM:  quick_sample = in_high ? amp_ff : sym_low;
         default:            quick_sample = '0;
      endcase
   end

   // triangle: magnitude of A times the offset, then divide, then restore the sign
   always_comb begin
      amp_abs    = amp_ff[SW-1] ? amp_neg : amp_ff;
      prod_mag   = pwg_pkg::PROD_WIDTH'(amp_abs) * pwg_pkg::PROD_WIDTH'(factor_ff);
      quo_ext    = {1'b0, div_quo};
      quo_signed = neg_ff ? (~quo_ext + {{SW{1'b0}}, 1'b1}) : quo_ext;
      amp_ext    = {amp_ff[SW-1], amp_ff};
      tri_full   = rising_ff ? quo_signed : (amp_ext - quo_signed);
   end

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign div_start = (state_ff == ST_MUL);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      amp_in        = amp_ff;
      period_in     = period_ff;
      high_in       = high_ff;
      total_in      = total_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      factor_in     = factor_ff;
      dvs_in        = dvs_ff;
      rising_in     = rising_ff;
      neg_in        = neg_ff;
      res_sample_in = res_sample_ff;
      res_phase_in  = res_phase_ff;
      res_last_in   = res_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_phase_in  = rsp_phase_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_we) begin
         unique case (csr_addr)
            pwg_pkg::CSR_WAVE_MODE:  mode_in   = csr_wdata[pwg_pkg::MODE_WIDTH-1:0];
            pwg_pkg::CSR_AMPLITUDE:  amp_in    = csr_wdata[SW-1:0];
            pwg_pkg::CSR_PERIOD_LEN: period_in = csr_wdata[PW-1:0];
            pwg_pkg::CSR_HIGH_LEN:   high_in   = csr_wdata[PW-1:0];
            pwg_pkg::CSR_TOTAL_LEN:  total_in  = csr_wdata[CW-1:0];
            default: ;
         endcase
      end

      // output register drains independently of the core
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               phase_in      = (j_inc >= {1'b0, per_eff}) ? '0 : j_inc[PW-1:0];
               count_in      = last_cur ? '0 : (cnt_cur + {{(CW-1){1'b0}}, 1'b1});
               res_phase_in  = j_cur;
               res_last_in   = last_cur;
               res_sample_in = quick_sample;
               rising_in     = in_high;
               factor_in     = in_high ? j_cur : (j_cur - high_eff);
               dvs_in        = in_high ? high_eff : (per_eff - high_eff);
               state_in      = (mode_ff == pwg_pkg::MODE_TRI) ? ST_MUL : ST_HOLD;
            end
         end
         ST_MUL: begin
            neg_in   = amp_ff[SW-1];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               res_sample_in = tri_full[SW-1:0];
               state_in      = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_sample_ff;
               rsp_phase_in  = res_phase_ff;
               rsp_last_in   = res_last_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      factor_ff     <= factor_in;
      dvs_ff        <= dvs_in;
      rising_ff     <= rising_in;
      neg_ff        <= neg_in;
      res_sample_ff <= res_sample_in;
      res_phase_ff  <= res_phase_in;
      res_last_ff   <= res_last_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_phase_ff  <= rsp_phase_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= pwg_pkg::MODE_RECT;
         amp_ff       <= '0;
         period_ff    <= {{(PW-1){1'b0}}, 1'b1};
         high_ff      <= '0;
         total_ff     <= {{(CW-1){1'b0}}, 1'b1};
         phase_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         amp_ff       <= amp_in;
         period_ff    <= period_in;
         high_ff      <= high_in;
         total_ff     <= total_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_phase_pos   = rsp_phase_ff;
   assign rsp_last_sample = rsp_last_ff;

   // a taken word closes the request side until the word leaves HOLD
   `PWG_ASSERT_NEXT(a_accept_blocks, req_valid && !req_stall, req_stall, "accept did not leave idle")
   // divider runs only while the sequencer waits on it
   `PWG_ASSERT(a_div_busy_in_div, !div_stat.busy || state_ff == ST_DIV, "divider busy outside DIV")
   `PWG_ASSERT(a_div_done_in_div, !div_stat.done || state_ff == ST_DIV, "divider done outside DIV")
   // a parked word moves to a free output register in the next cycle
   `PWG_ASSERT_NEXT(a_hold_drains, state_ff == ST_HOLD && out_free, rsp_valid_ff && state_ff == ST_IDLE, "parked word not delivered")

endmodule

// ===== sv/pwg_div.sv =====
// Digit-serial restoring divider, two quotient bits per cycle.
// Depends on pwg_pkg for widths and the status struct.
module pwg_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [pwg_pkg::PROD_WIDTH-1:0]        dividend,
   input  logic [pwg_pkg::PERIOD_WIDTH-1:0]      divisor,
   output pwg_pkg::div_stat_type                 stat,
   output logic [pwg_pkg::SAMPLE_WIDTH-1:0]      quotient
);

   logic [pwg_pkg::PERIOD_WIDTH-1:0]  rem_ff, rem_in;
   logic [pwg_pkg::PERIOD_WIDTH-1:0]  dvs_ff, dvs_in;
   logic [pwg_pkg::QUO_WIDTH-1:0]     sh_ff, sh_in;
   logic [pwg_pkg::DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [pwg_pkg::PERIOD_WIDTH:0]    step_a, step_b;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [pwg_pkg::PERIOD_WIDTH:0] div_step(
      input logic [pwg_pkg::PERIOD_WIDTH-1:0] rem,
      input logic                             bit_in,
      input logic [pwg_pkg::PERIOD_WIDTH-1:0] dvs
   );
      logic [pwg_pkg::PERIOD_WIDTH:0] trial;
      logic [pwg_pkg::PERIOD_WIDTH:0] diff;
      trial = {rem, bit_in};
      diff  = trial - {1'b0, dvs};
      if (trial >= {1'b0, dvs}) begin
         return {1'b1, diff[pwg_pkg::PERIOD_WIDTH-1:0]};
      end else begin
         return {1'b0, trial[pwg_pkg::PERIOD_WIDTH-1:0]};
      end
   endfunction

   always_comb begin
      step_a  = div_step(rem_ff, sh_ff[pwg_pkg::QUO_WIDTH-1], dvs_ff);
      step_b  = div_step(step_a[pwg_pkg::PERIOD_WIDTH-1:0],
                         sh_ff[pwg_pkg::QUO_WIDTH-2], dvs_ff);
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // high part is below the divisor, so the quotient fits the shift register
         rem_in  = pwg_pkg::PERIOD_WIDTH'(dividend >> pwg_pkg::QUO_WIDTH);
         sh_in   = dividend[pwg_pkg::QUO_WIDTH-1:0];
         dvs_in  = divisor;
         cnt_in  = pwg_pkg::DIV_CNT_WIDTH'(pwg_pkg::DIV_CYCLES);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = step_b[pwg_pkg::PERIOD_WIDTH-1:0];
         sh_in  = {sh_ff[pwg_pkg::QUO_WIDTH-3:0],
                   step_a[pwg_pkg::PERIOD_WIDTH], step_b[pwg_pkg::PERIOD_WIDTH]};
         cnt_in = cnt_ff - {{(pwg_pkg::DIV_CNT_WIDTH-1){1'b0}}, 1'b1};
         if (cnt_ff == {{(pwg_pkg::DIV_CNT_WIDTH-1){1'b0}}, 1'b1}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      sh_ff  <= sh_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = sh_ff[pwg_pkg::SAMPLE_WIDTH-1:0];

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for periodic_waveform_generator: directed and random runs.
// Compares each sample word with a model of the counters and all four modes.
// Depends on pwg_pkg (widths, register indexes, mode codes) and the block's RTL.
module testbench;

   localparam int SAMPLE_WIDTH   = pwg_pkg::SAMPLE_WIDTH;
   localparam int PERIOD_WIDTH   = pwg_pkg::PERIOD_WIDTH;
   localparam int COUNT_WIDTH    = pwg_pkg::COUNT_WIDTH;
   localparam int MODE_WIDTH     = pwg_pkg::MODE_WIDTH;
   localparam int CSR_ADDR_WIDTH = pwg_pkg::CSR_ADDR_WIDTH;
   localparam int CSR_DATA_WIDTH = pwg_pkg::CSR_DATA_WIDTH;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_TICKS = 1000;
   localparam int QUIET_TICKS  = 150;    // closing stretch with no idling
   localparam int SETTLE_TICKS = 24;     // wait after the drain before the verdict
   localparam int LIMIT_CYCLES = 600000;
   localparam int MAX_REPORTS  = 30;

   // the fourth mode code has no name in the package; it yields zero samples
   localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;
   localparam longint SAMPLE_TOP = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic [PERIOD_WIDTH-1:0]        phase_pos;
      logic                           last_sample;
   } sample_word_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic                           req_restart;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample;
   logic [PERIOD_WIDTH-1:0]        rsp_phase_pos;
   logic                           rsp_last_sample;
   logic                           csr_we;
   logic [CSR_ADDR_WIDTH-1:0]      csr_addr;
   logic [CSR_DATA_WIDTH-1:0]      csr_wdata;

   // our copy of the registers, reset values as in the block
   logic [MODE_WIDTH-1:0]          cfg_mode      = pwg_pkg::MODE_RECT;
   logic signed [SAMPLE_WIDTH-1:0] cfg_amplitude = '0;
   logic [PERIOD_WIDTH-1:0]        cfg_period    = PERIOD_WIDTH'(1);
   logic [PERIOD_WIDTH-1:0]        cfg_high      = '0;
   logic [COUNT_WIDTH-1:0]         cfg_total     = COUNT_WIDTH'(1);

   // our copy of the two counters
   logic [PERIOD_WIDTH-1:0]        phase_cnt  = '0;
   logic [COUNT_WIDTH-1:0]         sample_cnt = '0;

   sample_word_type expected_words[$];
   int unsigned     mismatches = 0;
   int unsigned     words_seen = 0;
   bit              idling     = 1'b1;

   periodic_waveform_generator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_phase_pos   (rsp_phase_pos),
      .rsp_last_sample (rsp_last_sample),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Model of one tick. Lengths of zero count as one, the high part is
   // clipped to the period, and a counter left beyond its length by a
   // register change restarts from zero on this tick.
   // ---------------------------------------------------------------------
   function automatic sample_word_type next_sample(input bit restart);
      longint          p, t, h, a, j, s;
      sample_word_type w;
      p = (cfg_period == 0) ? 1 : longint'(cfg_period);
      t = (cfg_total == 0) ? 1 : longint'(cfg_total);
      h = (longint'(cfg_high) > p) ? p : longint'(cfg_high);
      a = longint'(cfg_amplitude);
      if (restart) begin
         phase_cnt  = '0;
         sample_cnt = '0;
      end
      if (longint'(phase_cnt) >= p)
         phase_cnt = '0;
      if (longint'(sample_cnt) >= t)
         sample_cnt = '0;
      j = longint'(phase_cnt);
      w.last_sample = (longint'(sample_cnt) == t - 1);
      case (cfg_mode)
         pwg_pkg::MODE_RECT: s = (j < h) ? a : 0;
         // negating the most negative amplitude clips to the top code
         pwg_pkg::MODE_SYM:  s = (j < h) ? a : ((-a > SAMPLE_TOP) ? SAMPLE_TOP : -a);
         // both divisions truncate toward zero, as SV longint division does
         pwg_pkg::MODE_TRI:  s = (j < h) ? (j * a) / h : a - ((j - h) * a) / (p - h);
         default:            s = 0;
      endcase
      w.sample    = s[SAMPLE_WIDTH-1:0];
      w.phase_pos = j[PERIOD_WIDTH-1:0];
      phase_cnt   = (j + 1 >= p) ? '0 : PERIOD_WIDTH'(j + 1);
      sample_cnt  = w.last_sample ? '0 : sample_cnt + 1'b1;
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("ERROR: word %0d: %s", words_seen, msg);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stall bursts, then none once idling is cleared.
   // ---------------------------------------------------------------------
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (idling && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // each accepted word is checked against the oldest prediction
   always @(posedge clock) begin
      sample_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word, sample %0d phase %0d last %0b",
                                      rsp_sample, rsp_phase_pos, rsp_last_sample));
         end else begin
            want = expected_words.pop_front();
            if (rsp_sample !== want.sample)
               report_mismatch($sformatf("sample %0d, expected %0d",
                                         rsp_sample, want.sample));
            if (rsp_phase_pos !== want.phase_pos)
               report_mismatch($sformatf("phase_pos %0d, expected %0d",
                                         rsp_phase_pos, want.phase_pos));
            if (rsp_last_sample !== want.last_sample)
               report_mismatch($sformatf("last_sample %0b, expected %0b",
                                         rsp_last_sample, want.last_sample));
         end
         words_seen++;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Valid stays high from one word to the next unless a gap is taken,
   // so it is never dropped and raised in the same step.
   task automatic send_tick(input bit restart);
      int unsigned gap;
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      expected_words.push_back(next_sample(restart));
   endtask

   task automatic send_ticks(input int count, input bit restart_first);
      for (int i = 0; i < count; i++)
         send_tick(restart_first && i == 0);
   endtask

   // sender holds off until every predicted word has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // write enable is left high between writes; set_config drops it
   task automatic write_reg(input logic [CSR_ADDR_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         pwg_pkg::CSR_WAVE_MODE:  cfg_mode      = data[MODE_WIDTH-1:0];
         pwg_pkg::CSR_AMPLITUDE:  cfg_amplitude = data[SAMPLE_WIDTH-1:0];
         pwg_pkg::CSR_PERIOD_LEN: cfg_period    = data[PERIOD_WIDTH-1:0];
         pwg_pkg::CSR_HIGH_LEN:   cfg_high      = data[PERIOD_WIDTH-1:0];
         pwg_pkg::CSR_TOTAL_LEN:  cfg_total     = data[COUNT_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // registers change only with the block drained
   task automatic set_config(input logic [MODE_WIDTH-1:0]          mode,
                             input logic signed [SAMPLE_WIDTH-1:0] amp,
                             input logic [PERIOD_WIDTH-1:0]        period,
                             input logic [PERIOD_WIDTH-1:0]        high,
                             input logic [COUNT_WIDTH-1:0]         total);
      wait_for_results();
      write_reg(pwg_pkg::CSR_WAVE_MODE,  CSR_DATA_WIDTH'(mode));
      write_reg(pwg_pkg::CSR_AMPLITUDE,  CSR_DATA_WIDTH'(unsigned'(amp)));
      write_reg(pwg_pkg::CSR_PERIOD_LEN, CSR_DATA_WIDTH'(period));
      write_reg(pwg_pkg::CSR_HIGH_LEN,   CSR_DATA_WIDTH'(high));
      write_reg(pwg_pkg::CSR_TOTAL_LEN,  CSR_DATA_WIDTH'(total));
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // reset defaults, then both rectangular modes at the amplitude extremes
   task automatic test_rectangular();
      send_tick(1'b0);
      set_config(pwg_pkg::MODE_RECT, 16'sh7FFF, 16'd4, 16'd2, 32'd3);
      send_ticks(4, 1'b1);
      // negated minimum amplitude clips in the low half
      set_config(pwg_pkg::MODE_SYM, 16'sh8000, 16'd2, 16'd1, 32'd2);
      send_ticks(2, 1'b1);
   endtask

   task automatic test_triangle();
      set_config(pwg_pkg::MODE_TRI, 16'sh8000, 16'd5, 16'd2, 32'd5);
      send_ticks(5, 1'b1);
      // no rising part, longest period and run
      set_config(pwg_pkg::MODE_TRI, 16'sh7FFF, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
      send_ticks(2, 1'b1);
   endtask

   task automatic test_special_cases();
      // zero period and run, high part far beyond the period; the counters
      // left over from the last test are past the new lengths
      set_config(pwg_pkg::MODE_SYM, 16'sd5, 16'd0, 16'hFFFF, 32'd0);
      send_ticks(2, 1'b0);
      // spare mode code: counters run, samples stay zero
      set_config(MODE_UNUSED, 16'sd1234, 16'd3, 16'd1, 32'd4);
      send_ticks(2, 1'b1);
      // shrink period and run under running counters
      set_config(pwg_pkg::MODE_RECT, -16'sd1, 16'd10, 16'd4, 32'd10);
      send_ticks(5, 1'b1);
      set_config(pwg_pkg::MODE_RECT, -16'sd1, 16'd3, 16'd4, 32'd4);
      send_ticks(2, 1'b0);
   endtask

   // runs of random length under random settings, mostly short periods
   // so that wrap points and run ends come often
   task automatic test_random_runs();
      int unsigned                    done_ticks;
      int unsigned                    run_len;
      int unsigned                    pick;
      logic [MODE_WIDTH-1:0]          mode;
      logic signed [SAMPLE_WIDTH-1:0] amp;
      logic [PERIOD_WIDTH-1:0]        period;
      logic [PERIOD_WIDTH-1:0]        high;
      logic [COUNT_WIDTH-1:0]         total;
      done_ticks = 0;
      while (done_ticks < RANDOM_TICKS) begin
         pick = $urandom_range(0, 9);
         mode = (pick < 3) ? pwg_pkg::MODE_RECT : (pick < 6) ? pwg_pkg::MODE_SYM :
                (pick < 9) ? pwg_pkg::MODE_TRI : MODE_UNUSED;
         case ($urandom_range(0, 5))
            0:       amp = 16'sh8000;
            1:       amp = 16'sh7FFF;
            2:       amp = SAMPLE_WIDTH'($urandom_range(0, 2)) - 1'b1;
            default: amp = SAMPLE_WIDTH'($urandom);
         endcase
         case ($urandom_range(0, 11))
            0:       period = '0;
            1:       period = 16'hFFFF;
            2:       period = PERIOD_WIDTH'($urandom);
            default: period = PERIOD_WIDTH'($urandom_range(1, 16));
         endcase
         if ($urandom_range(0, 4) == 0)
            high = PERIOD_WIDTH'($urandom);
         else
            high = PERIOD_WIDTH'($urandom_range(0, int'(period) + 2));
         case ($urandom_range(0, 9))
            0:       total = '0;
            1:       total = 32'hFFFF_FFFF;
            2:       total = COUNT_WIDTH'($urandom);
            default: total = COUNT_WIDTH'($urandom_range(1, 48));
         endcase
         set_config(mode, amp, period, high, total);
         run_len = $urandom_range(8, 60);
         for (int unsigned k = 0; k < run_len; k++) begin
            if (done_ticks >= RANDOM_TICKS - QUIET_TICKS)
               idling = 1'b0;
            // a restart now and then, often at the start of a run
            send_tick((k == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 19) == 0));
            done_ticks++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_restart <= 1'b0;
      csr_we      <= 1'b0;
      csr_addr    <= '0;
      csr_wdata   <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_rectangular();
      test_triangle();
      test_special_cases();
      test_random_runs();

      wait_for_results();
      // room for any stray word to show up
      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pwg_pkg.sv
sv/pwg_div.sv
sv/periodic_waveform_generator.sv
dv/testbench.sv
